>>> rtl/core/nonuniform_color_quantizer_defines.svh
// Assertion macros used by the quantizer engine.
// Depends on nothing; each file that asserts includes it by bare name.
`ifndef NONUNIFORM_COLOR_QUANTIZER_DEFINES_SVH
`define NONUNIFORM_COLOR_QUANTIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define NCQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("ncq check failed");
`define NCQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ncq check failed");
`else
`define NCQ_ASSERT(lbl, clk, rstn, prop)
`define NCQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/ncq_pkg.sv
// Shared types and constants of the nonuniform color quantizer.
// Depends on nothing.
package ncq_pkg;
  localparam int NCQ_LEVELS = 256;
  localparam int NCQ_CHANNELS = 3;
  localparam int NCQ_QDEPTH = 2;
  localparam int DEF_PIXEL_COUNT_BITS = 20;
  localparam logic [3:0] LEVEL_BITS_RESET = 4'd2;
  localparam logic [3:0] LEVEL_BITS_MAX = 4'd8;
  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_MAP = 1'b1;
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BUILT = 1'b1;
  localparam logic REG_LEVEL_BITS = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ACC_RD, ST_ZERO, ST_WALK, ST_DONE, ST_MAP_CLS, ST_MAP_REP
  } eng_state_t;

  typedef struct packed {
    logic req_type;
    logic [NCQ_CHANNELS-1:0][7:0] pix;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [23:0] index;
  } res_t;
endpackage

>>> rtl/core/ncq_front.sv
// Front part: accepts input beats and queues them as commands for the engine.
// Depends on ncq_pkg.
module ncq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_req_type,
  input  logic [7:0]     in_pix_red,
  input  logic [7:0]     in_pix_green,
  input  logic [7:0]     in_pix_blue,
  input  logic           in_last_pixel,
  input  logic           pop,
  output ncq_pkg::q_head_t head
);
  import ncq_pkg::*;

  cmd_t       entries_r [NCQ_QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, do_pop;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.req_type = in_req_type;
    in_cmd.pix[0]   = in_pix_red;
    in_cmd.pix[1]   = in_pix_green;
    in_cmd.pix[2]   = in_pix_blue;
    in_cmd.last     = in_last_pixel;
  end

  assign in_ready   = (count_r != 2'(NCQ_QDEPTH));
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= in_cmd;
    end
  end
endmodule

>>> rtl/core/ncq_engine.sv
// Back part: histogram memories, table build walk and pixel mapping.
// Depends on ncq_pkg and nonuniform_color_quantizer_defines.svh.
`include "nonuniform_color_quantizer_defines.svh"
module ncq_engine #(
  parameter int PIXEL_COUNT_BITS = ncq_pkg::DEF_PIXEL_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ncq_pkg::q_head_t head,
  output logic             pop,
  input  logic [3:0]       level_bits,
  input  logic             slot_free,
  output logic             res_load,
  output ncq_pkg::res_t    res
);
  import ncq_pkg::*;

  localparam int CW = PIXEL_COUNT_BITS + 1;
  localparam int HW = CW + 9;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  logic [CW-1:0] hist_mem  [NCQ_CHANNELS][NCQ_LEVELS];
  logic [7:0]    class_mem [NCQ_CHANNELS][NCQ_LEVELS];
  logic [7:0]    rep_mem   [NCQ_CHANNELS][NCQ_LEVELS];

  eng_state_t state_r, state_nxt;
  logic [8:0]    cnt_r;
  logic          dv_r;
  logic [7:0]    lvl_r;
  logic [CW-1:0] total_r;
  cmd_t          cmd_r;
  logic [CW-1:0] hrd_r  [NCQ_CHANNELS];
  logic [7:0]    crd_r  [NCQ_CHANNELS];
  logic [7:0]    rrd_r  [NCQ_CHANNELS];
  logic [7:0]    mcls_r [NCQ_CHANNELS];
  logic [CW-1:0] sum_r  [NCQ_CHANNELS];
  logic [7:0]    cls_r  [NCQ_CHANNELS];
  logic [HW-1:0] hi_r   [NCQ_CHANNELS];
  logic          found_r [NCQ_CHANNELS];
  logic [7:0]    rep_r  [NCQ_CHANNELS];

  logic [3:0]    bits;
  logic [8:0]    mask_wide;
  logic [7:0]    last_class;
  logic [CW-1:0] step;
  logic [HW-1:0] step_x, half_x;

  logic          h_re, c_re, r_re, h_we, c_we;
  logic [7:0]    h_ra [NCQ_CHANNELS];
  logic [7:0]    c_ra [NCQ_CHANNELS];
  logic [7:0]    r_ra [NCQ_CHANNELS];
  logic [7:0]    h_wa [NCQ_CHANNELS];
  logic [CW-1:0] h_wd [NCQ_CHANNELS];
  logic [7:0]    c_wa;
  logic [7:0]    c_wd [NCQ_CHANNELS];
  logic          r_we [NCQ_CHANNELS];
  logic [7:0]    r_wa [NCQ_CHANNELS];
  logic [7:0]    r_wd [NCQ_CHANNELS];

  logic [CW:0]   acc   [NCQ_CHANNELS];
  logic [CW-1:0] sum_new [NCQ_CHANNELS];
  logic [HW-1:0] mid   [NCQ_CHANNELS];
  logic          hit   [NCQ_CHANNELS];
  logic          cut   [NCQ_CHANNELS];
  logic [7:0]    rep_new [NCQ_CHANNELS];
  logic          found_new [NCQ_CHANNELS];
  logic [CW:0]   inc   [NCQ_CHANNELS];
  logic [CW:0]   tot_inc;
  logic [23:0]   packed_idx;

  assign bits       = (level_bits > LEVEL_BITS_MAX) ? LEVEL_BITS_MAX : level_bits;
  assign mask_wide  = (9'd1 << bits) - 9'd1;
  assign last_class = mask_wide[7:0];
  assign step       = total_r >> bits;
  assign step_x     = HW'(step);
  assign half_x     = HW'(step >> 1);
  assign tot_inc    = {1'b0, total_r} + (CW+1)'(1);

  // Per-channel build arithmetic on the registered bin just read.
  always_comb begin
    for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
      acc[ch]       = {1'b0, sum_r[ch]} + {1'b0, hrd_r[ch]};
      sum_new[ch]   = acc[ch][CW] ? CNT_MAX : acc[ch][CW-1:0];
      mid[ch]       = hi_r[ch] - half_x;
      hit[ch]       = !found_r[ch] && (HW'(sum_new[ch]) > mid[ch]);
      found_new[ch] = found_r[ch] || hit[ch];
      rep_new[ch]   = hit[ch] ? lvl_r : rep_r[ch];
      cut[ch]       = (lvl_r == 8'(NCQ_LEVELS - 1)) ||
                      ((cls_r[ch] < last_class) && (HW'(sum_new[ch]) > hi_r[ch]));
      inc[ch]       = {1'b0, hrd_r[ch]} + (CW+1)'(1);
    end
  end

  always_comb begin
    packed_idx = (24'(mcls_r[0]) << {bits, 1'b0}) | (24'(mcls_r[1]) << bits) |
                 24'(mcls_r[2]);
  end

  // Next state, handshakes and memory port control.
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    res_load  = 1'b0;
    res       = '0;
    h_re = 1'b0;
    c_re = 1'b0;
    r_re = 1'b0;
    h_we = 1'b0;
    c_we = 1'b0;
    c_wa = lvl_r;
    for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
      h_ra[ch] = head.cmd.pix[ch];
      c_ra[ch] = head.cmd.pix[ch];
      r_ra[ch] = crd_r[ch] & last_class;
      h_wa[ch] = lvl_r;
      h_wd[ch] = '0;
      c_wd[ch] = cls_r[ch];
      r_we[ch] = 1'b0;
      r_wa[ch] = cls_r[ch];
      r_wd[ch] = found_new[ch] ? rep_new[ch] : 8'd0;
    end
    unique case (state_r)
      ST_CLEAR: begin
        h_we = 1'b1;
        c_we = 1'b1;
        c_wa = cnt_r[7:0];
        for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
          h_wa[ch] = cnt_r[7:0];
          c_wd[ch] = 8'd0;
          r_we[ch] = 1'b1;
          r_wa[ch] = cnt_r[7:0];
          r_wd[ch] = 8'd0;
        end
        if (cnt_r[7:0] == 8'(NCQ_LEVELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.cmd.req_type == REQ_MAP) begin
            c_re      = 1'b1;
            state_nxt = ST_MAP_CLS;
          end else begin
            h_re      = 1'b1;
            state_nxt = ST_ACC_RD;
          end
        end
      end
      ST_ACC_RD: begin
        h_we = 1'b1;
        for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
          h_wa[ch] = cmd_r.pix[ch];
          h_wd[ch] = inc[ch][CW] ? CNT_MAX : inc[ch][CW-1:0];
        end
        state_nxt = cmd_r.last ? ST_ZERO : ST_IDLE;
      end
      ST_ZERO: begin
        for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
          r_we[ch] = 1'b1;
          r_wa[ch] = cnt_r[7:0];
          r_wd[ch] = 8'd0;
        end
        if (cnt_r[7:0] == 8'(NCQ_LEVELS - 1)) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        h_re = !cnt_r[8];
        for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
          h_ra[ch] = cnt_r[7:0];
          r_we[ch] = dv_r && cut[ch];
        end
        h_we = dv_r;
        c_we = dv_r;
        if (dv_r && (lvl_r == 8'(NCQ_LEVELS - 1))) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          res_load  = 1'b1;
          res.kind  = KIND_BUILT;
          state_nxt = ST_IDLE;
        end
      end
      ST_MAP_CLS: begin
        r_re      = 1'b1;
        state_nxt = ST_MAP_REP;
      end
      ST_MAP_REP: begin
        if (slot_free) begin
          res_load  = 1'b1;
          res.kind  = KIND_PIXEL;
          res.red   = rrd_r[0];
          res.green = rrd_r[1];
          res.blue  = rrd_r[2];
          res.index = packed_idx;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control counters and build state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      dv_r    <= 1'b0;
      total_r <= '0;
    end else begin
      dv_r <= (state_r == ST_WALK) && !cnt_r[8];
      if ((state_r == ST_CLEAR) || (state_r == ST_ZERO) || (state_r == ST_WALK)) begin
        cnt_r <= (state_nxt == state_r) ? cnt_r + 9'd1 : 9'd0;
      end else begin
        cnt_r <= 9'd0;
      end
      if (state_r == ST_ACC_RD) begin
        total_r <= tot_inc[CW] ? CNT_MAX : tot_inc[CW-1:0];
      end else if (state_r == ST_DONE) begin
        total_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= cnt_r[7:0];
    if (pop) begin
      cmd_r <= head.cmd;
    end
    for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
      if (state_r == ST_MAP_CLS) begin
        mcls_r[ch] <= crd_r[ch] & last_class;
      end
      if (state_r == ST_ZERO) begin
        sum_r[ch]   <= '0;
        cls_r[ch]   <= 8'd0;
        hi_r[ch]    <= step_x;
        found_r[ch] <= 1'b0;
        rep_r[ch]   <= 8'd0;
      end else if ((state_r == ST_WALK) && dv_r) begin
        sum_r[ch] <= sum_new[ch];
        if (cut[ch]) begin
          found_r[ch] <= 1'b0;
          rep_r[ch]   <= 8'd0;
          if (cls_r[ch] < last_class) begin
            cls_r[ch] <= cls_r[ch] + 8'd1;
            hi_r[ch]  <= hi_r[ch] + step_x;
          end
        end else begin
          found_r[ch] <= found_new[ch];
          rep_r[ch]   <= rep_new[ch];
        end
      end
    end
  end

  // Memories: one write and one registered read per channel each.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
      if (h_we) begin
        hist_mem[ch][h_wa[ch]] <= h_wd[ch];
      end
      if (h_re) begin
        hrd_r[ch] <= hist_mem[ch][h_ra[ch]];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
      if (c_we) begin
        class_mem[ch][c_wa] <= c_wd[ch];
      end
      if (c_re) begin
        crd_r[ch] <= class_mem[ch][c_ra[ch]];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NCQ_CHANNELS; ch++) begin
      if (r_we[ch]) begin
        rep_mem[ch][r_wa[ch]] <= r_wd[ch];
      end
      if (r_re) begin
        rrd_r[ch] <= rep_mem[ch][r_ra[ch]];
      end
    end
  end

  `NCQ_ASSERT(a_pop_idle, clk, rst_n, pop |-> (state_r == ST_IDLE))
  `NCQ_ASSERT(a_load_free, clk, rst_n, res_load |-> slot_free)
  `NCQ_ASSERT(a_cls_bound, clk, rst_n, (state_r == ST_WALK) |-> (cls_r[0] <= last_class))
  `NCQ_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> (state_r == ST_CLEAR))
endmodule

>>> rtl/core/nonuniform_color_quantizer.sv
// Top level of the nonuniform color quantizer: configuration register,
// output register and the front and engine parts. Depends on ncq_pkg.
//
// Accumulate beats add a pixel to three 256-bin histograms; the accumulate
// beat marked last starts a build that cuts each channel into 2^level_bits
// classes (level_bits above 8 acting as 8) of about equal population and
// returns one beat with result_kind 1. Map beats return the three
// representative levels and the packed palette index. After reset the
// engine runs a clearing pass over its memories before it takes the first
// item; input beats are still queued meanwhile and configuration writes
// are taken at any time. The engine handles one item at a time: an
// accumulate is a read-modify-write of the bin memories, a map a class
// memory read, then a representative memory read, and a build one pass
// clearing the representative tables, then a walk of one level per cycle
// through all three channels in parallel. A two-entry command queue and
// the output register let either side stall on its own.
module nonuniform_color_quantizer #(
  parameter int PIXEL_COUNT_BITS = ncq_pkg::DEF_PIXEL_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_pix_red,
  input  logic [7:0]  in_pix_green,
  input  logic [7:0]  in_pix_blue,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [23:0] out_palette_index,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ncq_pkg::*;

  logic [3:0] level_bits_r;
  logic       out_valid_r;
  res_t       out_r;
  q_head_t    head;
  logic       pop;
  logic       slot_free;
  logic       res_load;
  res_t       res;

  // The register file has a single word; the upper address bit selects
  // nothing, so reads there return zero and writes are dropped.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_LEVEL_BITS) ? {28'd0, level_bits_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_bits_r <= LEVEL_BITS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_LEVEL_BITS)) begin
      level_bits_r <= cfg_pwdata[3:0];
    end
  end

  ncq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_pix_red    (in_pix_red),
    .in_pix_green  (in_pix_green),
    .in_pix_blue   (in_pix_blue),
    .in_last_pixel (in_last_pixel),
    .pop           (pop),
    .head          (head)
  );

  ncq_engine #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .level_bits (level_bits_r),
    .slot_free  (slot_free),
    .res_load   (res_load),
    .res        (res)
  );

  // The output register takes a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_r.kind;
  assign out_red           = out_r.red;
  assign out_green         = out_r.green;
  assign out_blue          = out_r.blue;
  assign out_palette_index = out_r.index;
endmodule

>>> tb/tb_nonuniform_color_quantizer.sv
// Self-checking testbench of the nonuniform color quantizer.
// Holds a histogram and table predictor in a scoreboard class and drives the block
// through its pixel, result and register ports. Depends on ncq_pkg and the RTL.
module tb_nonuniform_color_quantizer;
  timeunit 1ns;
  timeprecision 1ps;
  import ncq_pkg::*;

  localparam int CNT_BITS = DEF_PIXEL_COUNT_BITS;
  localparam int CNT_MAX = (1 << (CNT_BITS + 1)) - 1;
  localparam logic [2:0] ADDR_LEVEL_BITS = 3'd4 * REG_LEVEL_BITS;
  localparam int CYCLE_LIMIT = 3000000;

  // One result beat as the block presents it.
  typedef struct packed {
    logic kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [23:0] index;
  } quant_result_t;

  // Mirrors the histograms and lookup tables and queues the result beats
  // that each accepted pixel beat should produce.
  class quant_scoreboard;
    int unsigned hist[3][256];
    int unsigned total;
    logic [7:0] class_of[3][256];
    logic [7:0] rep_of[3][256];
    logic [3:0] level_bits;
    quant_result_t pending[$];
    int errors;

    function new();
      level_bits = LEVEL_BITS_RESET;
      total = 0;
      errors = 0;
      foreach (hist[c, l]) begin
        hist[c][l] = 0;
        class_of[c][l] = 0;
        rep_of[c][l] = 0;
      end
    endfunction

    function int unsigned eff_bits();
      return (level_bits > LEVEL_BITS_MAX) ? LEVEL_BITS_MAX : level_bits;
    endfunction

    // Equal-population cut of one channel's cumulative histogram.
    function void cut_channel(int ch, int unsigned bits);
      int unsigned last_cls, cls, rep, run;
      longint unsigned step, hi, mid;
      bit found, cut;
      last_cls = (1 << bits) - 1;
      step = total >> bits;
      cls = 0;
      found = 0;
      rep = 0;
      run = 0;
      for (int l = 0; l < 256; l++) rep_of[ch][l] = 0;
      for (int l = 0; l < 256; l++) begin
        run += hist[ch][l];
        if (run > CNT_MAX) run = CNT_MAX;
        class_of[ch][l] = cls;
        hi = (cls + 1) * step;
        mid = hi - step / 2;
        if (!found && run > mid) begin
          found = 1;
          rep = l;
        end
        cut = (l == 255) || (cls < last_cls && run > hi);
        if (cut) begin
          rep_of[ch][cls] = found ? rep : 0;
          if (cls < last_cls) cls++;
          found = 0;
          rep = 0;
        end
      end
    endfunction

    function void note_pixel(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic last);
      logic [7:0] pix[3];
      quant_result_t res;
      int unsigned bits, mask, packed_idx, cls;
      pix[0] = r;
      pix[1] = g;
      pix[2] = b;
      bits = eff_bits();
      res = '0;
      if (req == REQ_ACCUM) begin
        for (int c = 0; c < 3; c++)
          if (hist[c][pix[c]] < CNT_MAX) hist[c][pix[c]]++;
        if (total < CNT_MAX) total++;
        if (!last) return;
        for (int c = 0; c < 3; c++) cut_channel(c, bits);
        foreach (hist[c, l]) hist[c][l] = 0;
        total = 0;
        res.kind = KIND_BUILT;
      end else begin
        mask = (1 << bits) - 1;
        packed_idx = 0;
        res.kind = KIND_PIXEL;
        for (int c = 0; c < 3; c++) begin
          cls = class_of[c][pix[c]] & mask;
          packed_idx = (packed_idx << bits) | cls;
          if (c == 0) res.red = rep_of[c][cls];
          else if (c == 1) res.green = rep_of[c][cls];
          else res.blue = rep_of[c][cls];
        end
        res.index = packed_idx[23:0];
      end
      pending.push_back(res);
    endfunction

    function void check_result(quant_result_t got);
      quant_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.kind !== exp_res.kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $realtime, exp_res.kind, got.kind);
        errors++;
      end
      if (got.red !== exp_res.red) begin
        $display("%0t: out_red expected %0d actual %0d", $realtime, exp_res.red, got.red);
        errors++;
      end
      if (got.green !== exp_res.green) begin
        $display("%0t: out_green expected %0d actual %0d", $realtime, exp_res.green,
                 got.green);
        errors++;
      end
      if (got.blue !== exp_res.blue) begin
        $display("%0t: out_blue expected %0d actual %0d", $realtime, exp_res.blue, got.blue);
        errors++;
      end
      if (got.index !== exp_res.index) begin
        $display("%0t: palette_index expected %h actual %h", $realtime, exp_res.index,
                 got.index);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [7:0] in_pix_red = '0;
  logic [7:0] in_pix_green = '0;
  logic [7:0] in_pix_blue = '0;
  logic in_last_pixel = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_result_kind;
  logic [7:0] out_red, out_green, out_blue;
  logic [23:0] out_palette_index;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  quant_scoreboard board = new();
  int cycle_count = 0;
  bit stimulus_done = 1'b0;
  // Selects how the receiver stalls: 0 never, 1 random, 2 long periodic stalls.
  int stall_mode = 1;

  nonuniform_color_quantizer i_dut (.*);

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Input beats are noted at the edge that accepts them, result beats are
  // checked at the edge that accepts them.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_pixel(in_req_type, in_pix_red, in_pix_green, in_pix_blue, in_last_pixel);
    if (rst_n && out_valid && out_ready)
      board.check_result({out_result_kind, out_red, out_green, out_blue, out_palette_index});
  end

  // Receiver stall pattern, updated on the falling edge.
  always @(negedge clk) begin
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= ((cycle_count % 23) < 12);
      end
    endcase
  end

  // Presents one pixel beat and holds it until it is accepted. The ready
  // flag only moves at a rising edge, so its value at the falling edge
  // tells whether the next rising edge takes the beat.
  task automatic send_pixel(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic last);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_pix_red <= r;
    in_pix_green <= g;
    in_pix_blue <= b;
    in_last_pixel <= last;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
  endtask

  // Random gap between bursts; bursts themselves run back to back.
  task automatic maybe_gap(ref int burst_left);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      pause_input();
      repeat (gap) @(negedge clk);
    end
  endtask

  // Waits until every expected result beat has arrived, plus a margin for
  // any accumulate still being absorbed.
  task automatic drain();
    pause_input();
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_level_bits(logic [3:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_LEVEL_BITS;
    cfg_pwdata <= {$urandom_range(0, 65535), 12'h000, value} ;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.level_bits = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // A frame of random pixels spread around one random base, ended by a build,
  // followed by map beats. The clustering makes the population cuts uneven.
  task automatic run_frame(int n_acc, int n_map, ref int burst_left);
    logic [7:0] base_r, base_g, base_b;
    int spread;
    base_r = $urandom;
    base_g = $urandom;
    base_b = $urandom;
    spread = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(4, 60);
    for (int k = 0; k < n_acc; k++) begin
      maybe_gap(burst_left);
      send_pixel(REQ_ACCUM, base_r + $urandom_range(0, spread),
                 base_g + $urandom_range(0, spread), base_b + $urandom_range(0, spread),
                 k == n_acc - 1);
    end
    for (int k = 0; k < n_map; k++) begin
      maybe_gap(burst_left);
      send_pixel(REQ_MAP, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int burst_left;
    logic [3:0] setting;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A map before any build must return all zeros.
    send_pixel(REQ_MAP, 8'hFF, 8'h00, 8'hA5, 1'b1);
    // A frame with the field extremes, built at the reset setting.
    send_pixel(REQ_ACCUM, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(REQ_ACCUM, 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_pixel(REQ_ACCUM, 8'h55, 8'hAA, 8'h0F, 1'b0);
    send_pixel(REQ_ACCUM, 8'hAA, 8'h55, 8'hF0, 1'b1);
    send_pixel(REQ_MAP, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(REQ_MAP, 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_pixel(REQ_MAP, 8'h80, 8'h7F, 8'h01, 1'b1);
    // A build from a single pixel: the step is zero, so each class but the last
    // takes a single level and the last class holds the rest.
    send_pixel(REQ_ACCUM, 8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(REQ_MAP, 8'h00, 8'h10, 8'hFF, 1'b0);
    drain();
    // Register changed after a build: mapping uses the new width.
    write_level_bits(4'd8);
    send_pixel(REQ_MAP, 8'h00, 8'hFF, 8'h01, 1'b0);
    drain();
    // One class, palette index zero.
    write_level_bits(4'd0);
    send_pixel(REQ_ACCUM, 8'h12, 8'h34, 8'h56, 1'b0);
    send_pixel(REQ_ACCUM, 8'h9A, 8'hBC, 8'hDE, 1'b1);
    send_pixel(REQ_MAP, 8'h12, 8'hBC, 8'hFF, 1'b0);
    drain();
    // Out-of-range width acts as 8 bits.
    write_level_bits(4'd15);
    for (int k = 0; k < 6; k++) send_pixel(REQ_ACCUM, k * 40, 255 - k * 40, k, k == 5);
    send_pixel(REQ_MAP, 8'd40, 8'd215, 8'd3, 1'b0);
    drain();

    // Random part: frames at several settings, including 1 and the largest, 8.
    for (int frame = 0; frame < 26; frame++) begin
      stall_mode = frame % 3;
      if (frame % 4 == 0) begin
        drain();
        setting = (frame == 0) ? 4'd1 : (frame == 4) ? 4'd8 : $urandom_range(0, 15);
        write_level_bits(setting);
      end
      run_frame($urandom_range(2, 30), $urandom_range(2, 14), burst_left);
      // Stray maps and accumulates between frames are the noise part.
      if (frame % 5 == 2)
        send_pixel($urandom_range(0, 1), $urandom, $urandom, $urandom, 1'b0);
    end
    // One large frame so that bigger populations are cut.
    stall_mode = 1;
    run_frame(120, 40, burst_left);
    drain();
    write_level_bits(4'd3);
    send_pixel(REQ_MAP, 8'h40, 8'h80, 8'hC0, 1'b0);

    drain();
    stimulus_done = 1'b1;
    repeat (40) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (board.pending.size() != 0)
        $display("%0t: %0d expected results never arrived", $realtime, board.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
